FILE: src/ray_distance_to_planar_depth_assert.svh
// Assertion macros for the ray distance to planar depth block.
// Included by the checker; expects i_clk and i_rst_n in scope.
`ifndef RAY_DISTANCE_TO_PLANAR_DEPTH_ASSERT_SVH
`define RAY_DISTANCE_TO_PLANAR_DEPTH_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RDPD_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rdpd check failed");

// next-cycle implication, disabled in reset
`define RDPD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rdpd check failed");

// condition in the cycle after a reset cycle
`define RDPD_ASSERT_RESET(lbl, post) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (post)) \
        else $error("rdpd reset check failed");

`endif

FILE: src/rdpd_pkg.sv
// Shared types and constants for the ray distance to planar depth block.
// No dependencies; imported by the interfaces, the flow control, the top level and the checker.
package rdpd_pkg;

    localparam int PIX_W   = 10;
    localparam int PIX_MAX = 2**PIX_W - 1;
    localparam int RAY_W   = 20;
    localparam int DEPTH_W = 16;
    localparam int CTR_W   = 14;
    localparam int FOC_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REG_CENTER_COL = 2'd0;
    localparam logic [1:0] REG_CENTER_ROW = 2'd1;
    localparam logic [1:0] REG_FOCAL_COL  = 2'd2;
    localparam logic [1:0] REG_FOCAL_ROW  = 2'd3;

    localparam logic [CTR_W-1:0]        CCOL_RST = 14'd5112;
    localparam logic [CTR_W-1:0]        CROW_RST = 14'd3832;
    localparam logic signed [FOC_W-1:0] FCOL_RST = 16'sd7699;
    localparam logic signed [FOC_W-1:0] FROW_RST = -16'sd7680;

    localparam int DIV_STAGES  = 5;
    localparam int DIV_PER     = 4;
    localparam int SQRT_STAGES = 7;
    localparam int SQRT_PER    = 3;
    localparam int RCP_STAGES  = 5;
    localparam int RCP_PER     = 4;
    localparam int RCP_STEPS   = 17;

    localparam int G_SQR       = 1 + DIV_STAGES;
    localparam int G_SUM       = G_SQR + 1;
    localparam int G_RT0       = G_SUM + 1;
    localparam int G_RCP0      = G_RT0 + SQRT_STAGES;
    localparam int G_MUL       = G_RCP0 + RCP_STAGES;
    localparam int PIPE_STAGES = G_MUL + 1;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
        logic [PIPE_STAGES-1:0] valid;
    } t_flow;

endpackage

FILE: src/rdpd_if.sv
// Stream interfaces for depth pixel beats in and planar depth beats out.
// Depends on rdpd_pkg for field widths.
interface rdpd_in_if import rdpd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_col;
    logic [PIX_W-1:0]   pixel_row;
    logic [RAY_W-1:0]   ray_mm_q4;

    modport source (output valid, output pixel_col, output pixel_row, output ray_mm_q4,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input ray_mm_q4,
                    output ready);
endinterface

interface rdpd_out_if import rdpd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_mm;

    modport source (output valid, output depth_mm, input ready);
    modport sink   (input valid, input depth_mm, output ready);
endinterface

FILE: src/rdpd_flow.sv
// Pipeline flow control: per-stage valid bits and load enables with bubble collapse.
// Depends on rdpd_pkg for the stage count and the t_flow struct.
module rdpd_flow import rdpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    output t_flow o_flow
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] w_load;

    // load a stage when the sink takes a beat or some stage at or after it is empty
    for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_load
        assign w_load[k] = i_out_ready || !(&r_valid[PIPE_STAGES-1:k]);
    end

    always_comb begin
        n_valid[0] = w_load[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_valid[k] = w_load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_flow.load  = w_load;
    assign o_flow.valid = r_valid;

endmodule

FILE: src/ray_distance_to_planar_depth.sv
// Throughput: one beat per cycle; a stalled sink holds the last stage and empty
// stages ahead of it keep filling, so nothing is lost or repeated.
// Stages: offset, 5 divider stages, square, sum, 7 root stages, 5 reciprocal stages, scale.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
module ray_distance_to_planar_depth import rdpd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rdpd_in_if.sink            i_pix,
    rdpd_out_if.source         o_depth,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int COL_LIM = (MAX_WIDTH - 1 > PIX_MAX) ? PIX_MAX : MAX_WIDTH - 1;
    localparam int ROW_LIM = (MAX_HEIGHT - 1 > PIX_MAX) ? PIX_MAX : MAX_HEIGHT - 1;
    localparam logic [PIX_W-1:0] COL_MAX = COL_LIM[PIX_W-1:0];
    localparam logic [PIX_W-1:0] ROW_MAX = ROW_LIM[PIX_W-1:0];
    localparam logic [19:0] NORM_MAX = 20'hFFFFF;
    localparam logic [41:0] SUM_ONE  = 42'h1_0000_0000;
    localparam logic [20:0] RCP_REM0 = 21'h8000;

    typedef struct packed {
        logic [20:0] rem;
        logic [19:0] w;
    } t_div;

    typedef struct packed {
        logic [41:0] x;
        logic [41:0] res;
    } t_sq;

    function automatic logic [CTR_W-1:0] offset_mag(logic [PIX_W-1:0] coord,
                                                     logic [CTR_W-1:0] center);
        logic [CTR_W-1:0] pos;
        pos = {coord, 4'b0};
        return (pos >= center) ? pos - center : center - pos;
    endfunction

    function automatic logic [FOC_W-1:0] abs_focal(logic [FOC_W-1:0] raw);
        return raw[FOC_W-1] ? FOC_W'(~raw + 16'd1) : raw;
    endfunction

    function automatic logic sat_flag(logic [CTR_W-1:0] mag, logic [FOC_W-1:0] f);
        return (mag != '0) && ({6'b0, mag} >= {f, 4'b0});
    endfunction

    function automatic t_div div_init(logic [CTR_W-1:0] mag);
        t_div o;
        o.rem = 21'(mag[13:4]);
        o.w   = {mag[3:0], 16'h0};
        return o;
    endfunction

    function automatic t_div div_step(t_div s, logic [20:0] d);
        t_div        o;
        logic [21:0] t;
        logic        ge;
        t  = {s.rem, s.w[19]};
        ge = (t != '0) && (t >= {1'b0, d});
        o.rem = ge ? 21'(t - {1'b0, d}) : t[20:0];
        o.w   = {s.w[18:0], ge};
        return o;
    endfunction

    function automatic t_sq sqrt_step(t_sq s, int unsigned sh);
        t_sq         o;
        logic [41:0] bitv;
        logic [41:0] sum;
        bitv = 42'd1 << sh;
        sum  = s.res + bitv;
        if (s.x >= sum) begin
            o.x   = s.x - sum;
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.x   = s.x;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    logic [CTR_W-1:0] r_ccol;
    logic [CTR_W-1:0] r_crow;
    logic [FOC_W-1:0] r_fcol;
    logic [FOC_W-1:0] r_frow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccol <= CCOL_RST;
            r_crow <= CROW_RST;
            r_fcol <= FCOL_RST;
            r_frow <= FROW_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_CENTER_COL: r_ccol <= pwdata[CTR_W-1:0];
                REG_CENTER_ROW: r_crow <= pwdata[CTR_W-1:0];
                REG_FOCAL_COL:  r_fcol <= pwdata[FOC_W-1:0];
                REG_FOCAL_ROW:  r_frow <= pwdata[FOC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CENTER_COL: prdata = DATA_W'(r_ccol);
            REG_CENTER_ROW: prdata = DATA_W'(r_crow);
            REG_FOCAL_COL:  prdata = {{(DATA_W-FOC_W){r_fcol[FOC_W-1]}}, r_fcol};
            REG_FOCAL_ROW:  prdata = {{(DATA_W-FOC_W){r_frow[FOC_W-1]}}, r_frow};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    t_flow w_flow;

    rdpd_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_ready (o_depth.ready),
        .o_flow      (w_flow)
    );

    assign i_pix.ready   = w_flow.load[0];
    assign o_depth.valid = w_flow.valid[PIPE_STAGES-1];

    logic [PIX_W-1:0] w_col;
    logic [PIX_W-1:0] w_row;
    logic [CTR_W-1:0] w_mag_a;
    logic [CTR_W-1:0] w_mag_b;
    logic [FOC_W-1:0] w_fa;
    logic [FOC_W-1:0] w_fb;

    assign w_col   = (i_pix.pixel_col > COL_MAX) ? COL_MAX : i_pix.pixel_col;
    assign w_row   = (i_pix.pixel_row > ROW_MAX) ? ROW_MAX : i_pix.pixel_row;
    assign w_mag_a = offset_mag(w_col, r_ccol);
    assign w_mag_b = offset_mag(w_row, r_crow);
    assign w_fa    = abs_focal(r_fcol);
    assign w_fb    = abs_focal(r_frow);

    logic [RAY_W-1:0] r_ray [0:G_MUL-1];
    t_div             r_div_a [0:DIV_STAGES];
    t_div             r_div_b [0:DIV_STAGES];
    t_div             n_div_a [1:DIV_STAGES];
    t_div             n_div_b [1:DIV_STAGES];
    logic             r_sat_a [0:DIV_STAGES];
    logic             r_sat_b [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_flow.load[0]) begin
            r_ray[0]   <= i_pix.ray_mm_q4;
            r_div_a[0] <= div_init(w_mag_a);
            r_div_b[0] <= div_init(w_mag_b);
            r_sat_a[0] <= sat_flag(w_mag_a, w_fa);
            r_sat_b[0] <= sat_flag(w_mag_b, w_fb);
        end
    end

    for (genvar k = 1; k < G_MUL; k++) begin : g_ray
        always_ff @(posedge i_clk) begin
            if (w_flow.load[k]) begin
                r_ray[k] <= r_ray[k-1];
            end
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
        always_comb begin
            t_div a;
            t_div b;
            a = r_div_a[j-1];
            b = r_div_b[j-1];
            for (int i = 0; i < DIV_PER; i++) begin
                a = div_step(a, {5'b0, w_fa});
                b = div_step(b, {5'b0, w_fb});
            end
            n_div_a[j] = a;
            n_div_b[j] = b;
        end

        always_ff @(posedge i_clk) begin
            if (w_flow.load[j]) begin
                r_div_a[j] <= n_div_a[j];
                r_div_b[j] <= n_div_b[j];
                r_sat_a[j] <= r_sat_a[j-1];
                r_sat_b[j] <= r_sat_b[j-1];
            end
        end
    end

    logic [19:0] w_na;
    logic [19:0] w_nb;
    logic [39:0] w_sq_a;
    logic [39:0] w_sq_b;
    logic [39:0] r_sq_a;
    logic [39:0] r_sq_b;

    assign w_na   = r_sat_a[DIV_STAGES] ? NORM_MAX : r_div_a[DIV_STAGES].w;
    assign w_nb   = r_sat_b[DIV_STAGES] ? NORM_MAX : r_div_b[DIV_STAGES].w;
    assign w_sq_a = w_na * w_na;
    assign w_sq_b = w_nb * w_nb;

    always_ff @(posedge i_clk) begin
        if (w_flow.load[G_SQR]) begin
            r_sq_a <= w_sq_a;
            r_sq_b <= w_sq_b;
        end
    end

    t_sq r_sqrt [0:SQRT_STAGES];
    t_sq n_sqrt [1:SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_flow.load[G_SUM]) begin
            r_sqrt[0].x   <= {2'b0, r_sq_a} + {2'b0, r_sq_b} + SUM_ONE;
            r_sqrt[0].res <= '0;
        end
    end

    for (genvar j = 1; j <= SQRT_STAGES; j++) begin : g_sqrt
        always_comb begin
            t_sq st;
            st = r_sqrt[j-1];
            for (int i = 0; i < SQRT_PER; i++) begin
                st = sqrt_step(st, 2 * (20 - ((j - 1) * SQRT_PER + i)));
            end
            n_sqrt[j] = st;
        end

        always_ff @(posedge i_clk) begin
            if (w_flow.load[G_RT0 + j - 1]) begin
                r_sqrt[j] <= n_sqrt[j];
            end
        end
    end

    t_div        r_rcp [1:RCP_STAGES];
    t_div        n_rcp [1:RCP_STAGES];
    logic [20:0] r_q   [1:RCP_STAGES];
    logic [20:0] w_q   [1:RCP_STAGES];
    t_div        w_rcp_src [1:RCP_STAGES];

    for (genvar j = 1; j <= RCP_STAGES; j++) begin : g_rcp
        if (j == 1) begin : g_first
            assign w_q[j]       = r_sqrt[SQRT_STAGES].res[20:0];
            assign w_rcp_src[j] = '{rem: RCP_REM0, w: 20'h0};
        end else begin : g_next
            assign w_q[j]       = r_q[j-1];
            assign w_rcp_src[j] = r_rcp[j-1];
        end

        always_comb begin
            t_div st;
            st = w_rcp_src[j];
            for (int i = 0; i < RCP_PER; i++) begin
                if ((j - 1) * RCP_PER + i < RCP_STEPS) begin
                    st = div_step(st, w_q[j]);
                end
            end
            n_rcp[j] = st;
        end

        always_ff @(posedge i_clk) begin
            if (w_flow.load[G_RCP0 + j - 1]) begin
                r_rcp[j] <= n_rcp[j];
                r_q[j]   <= w_q[j];
            end
        end
    end

    logic [36:0]        w_prod;
    logic [DEPTH_W-1:0] r_depth;

    assign w_prod = r_ray[G_MUL-1] * r_rcp[RCP_STAGES].w[16:0];

    always_ff @(posedge i_clk) begin
        if (w_flow.load[G_MUL]) begin
            r_depth <= w_prod[35:20];
        end
    end

    assign o_depth.depth_mm = r_depth;

endmodule

FILE: src/rdpd_checker.sv
// Port-level checker for the ray distance to planar depth block, bound to the top level.
// Depends on rdpd_pkg and the assertion macros header.
`include "ray_distance_to_planar_depth_assert.svh"

module rdpd_checker import rdpd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DEPTH_W-1:0] i_out_depth
);

    `RDPD_ASSERT_NEXT(a_out_hold_valid, i_out_valid && !i_out_ready, i_out_valid)
    `RDPD_ASSERT_NEXT(a_out_hold_data, i_out_valid && !i_out_ready, $stable(i_out_depth))
    `RDPD_ASSERT_SAME(a_ready_follows_sink, i_out_ready, i_in_ready)
    `RDPD_ASSERT_SAME(a_stall_only_when_full, i_in_valid && !i_in_ready, i_out_valid)
    `RDPD_ASSERT_RESET(a_reset_empties, !i_out_valid)

endmodule

bind ray_distance_to_planar_depth rdpd_checker u_rdpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_depth.valid),
    .i_out_ready (o_depth.ready),
    .i_out_depth (o_depth.depth_mm)
);
